>>> rtl/core/ocib_pkg.sv
// ----------------------------------------------------------------------------
// OLED character to I2C bytes: shared package
// Bus codes, cursor command bases, byte sequence indexes and the 6x8 font.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ocib_pkg;

  // Defaults for the display geometry parameters of the top level.
  localparam int unsigned PAGE_COUNT_DEF  = 8;
  localparam int unsigned PIXEL_WIDTH_DEF = 128;

  // Character geometry and input limits.
  localparam logic [4:0] MAX_COLUMN = 5'd20;
  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd126;

  // Display address after reset.
  localparam logic [7:0] ADDR_RESET = 8'd120;

  // Control bytes.
  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;

  // Cursor command bases.
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_COL_LO = 8'h00;

  // Transaction indexes within one character.
  localparam logic [3:0] TXN_PAGE   = 4'd0;
  localparam logic [3:0] TXN_COL_HI = 4'd1;
  localparam logic [3:0] TXN_COL_LO = 4'd2;
  localparam logic [3:0] TXN_GLYPH0 = 4'd3;
  localparam logic [3:0] TXN_LAST   = 4'd8;

  // Byte positions within one transaction.
  localparam logic [1:0] POS_ADDR    = 2'd0;
  localparam logic [1:0] POS_CTRL    = 2'd1;
  localparam logic [1:0] POS_PAYLOAD = 2'd2;

  // 6x8 font for codes 32 to 126; the leftmost column is in the top byte.
  function automatic logic [47:0] font_glyph(input logic [6:0] idx);
    logic [47:0] g;
    case (idx)
      7'd0:  g = 48'h000000000000;
      7'd1:  g = 48'h00005F000000;
      7'd2:  g = 48'h000700070000;
      7'd3:  g = 48'h147F147F1400;
      7'd4:  g = 48'h242A7F2A1200;
      7'd5:  g = 48'h231308646200;
      7'd6:  g = 48'h364955225000;
      7'd7:  g = 48'h000503000000;
      7'd8:  g = 48'h001C22410000;
      7'd9:  g = 48'h0041221C0000;
      7'd10: g = 48'h14083E081400;
      7'd11: g = 48'h08083E080800;
      7'd12: g = 48'h005030000000;
      7'd13: g = 48'h080808080800;
      7'd14: g = 48'h006060000000;
      7'd15: g = 48'h201008040200;
      7'd16: g = 48'h3E5149453E00;
      7'd17: g = 48'h00427F400000;
      7'd18: g = 48'h426151494600;
      7'd19: g = 48'h2141454B3100;
      7'd20: g = 48'h1814127F1000;
      7'd21: g = 48'h274545453900;
      7'd22: g = 48'h3C4A49493000;
      7'd23: g = 48'h017109050300;
      7'd24: g = 48'h364949493600;
      7'd25: g = 48'h064949291E00;
      7'd26: g = 48'h003636000000;
      7'd27: g = 48'h005636000000;
      7'd28: g = 48'h081422410000;
      7'd29: g = 48'h141414141400;
      7'd30: g = 48'h004122140800;
      7'd31: g = 48'h020151090600;
      7'd32: g = 48'h324979413E00;
      7'd33: g = 48'h7E1111117E00;
      7'd34: g = 48'h7F4949493600;
      7'd35: g = 48'h3E4141412200;
      7'd36: g = 48'h7F4141221C00;
      7'd37: g = 48'h7F4949494100;
      7'd38: g = 48'h7F0909090100;
      7'd39: g = 48'h3E4149497A00;
      7'd40: g = 48'h7F0808087F00;
      7'd41: g = 48'h00417F410000;
      7'd42: g = 48'h2040413F0100;
      7'd43: g = 48'h7F0814224100;
      7'd44: g = 48'h7F4040404000;
      7'd45: g = 48'h7F020C027F00;
      7'd46: g = 48'h7F0408107F00;
      7'd47: g = 48'h3E4141413E00;
      7'd48: g = 48'h7F0909090600;
      7'd49: g = 48'h3E4151215E00;
      7'd50: g = 48'h7F0919294600;
      7'd51: g = 48'h464949493100;
      7'd52: g = 48'h01017F010100;
      7'd53: g = 48'h3F4040403F00;
      7'd54: g = 48'h1F2040201F00;
      7'd55: g = 48'h3F4038403F00;
      7'd56: g = 48'h631408146300;
      7'd57: g = 48'h070870080700;
      7'd58: g = 48'h615149454300;
      7'd59: g = 48'h007F41410000;
      7'd60: g = 48'h020408102000;
      7'd61: g = 48'h0041417F0000;
      7'd62: g = 48'h040201020400;
      7'd63: g = 48'h404040404000;
      7'd64: g = 48'h000102040000;
      7'd65: g = 48'h205454547800;
      7'd66: g = 48'h7F4844443800;
      7'd67: g = 48'h384444442000;
      7'd68: g = 48'h384444487F00;
      7'd69: g = 48'h385454541800;
      7'd70: g = 48'h087E09010200;
      7'd71: g = 48'h0C5252523E00;
      7'd72: g = 48'h7F0804047800;
      7'd73: g = 48'h00447D400000;
      7'd74: g = 48'h2040443D0000;
      7'd75: g = 48'h7F1028440000;
      7'd76: g = 48'h00417F400000;
      7'd77: g = 48'h7C0418047800;
      7'd78: g = 48'h7C0804047800;
      7'd79: g = 48'h384444443800;
      7'd80: g = 48'h7C1414140800;
      7'd81: g = 48'h081414187C00;
      7'd82: g = 48'h7C0804040800;
      7'd83: g = 48'h485454542000;
      7'd84: g = 48'h043F44402000;
      7'd85: g = 48'h3C4040207C00;
      7'd86: g = 48'h1C2040201C00;
      7'd87: g = 48'h3C4030403C00;
      7'd88: g = 48'h442810284400;
      7'd89: g = 48'h0C5050503C00;
      7'd90: g = 48'h4464544C4400;
      7'd91: g = 48'h000836410000;
      7'd92: g = 48'h00007F000000;
      7'd93: g = 48'h004136080000;
      7'd94: g = 48'h080408100800;
      default: g = 48'h000000000000;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/oled_char_to_i2c_bytes.sv
// An item accepted into an empty block is registered in the input stage and then in the
// byte sequencer before its first bus byte shows. The output byte sequencer sets the pace:
// one bus byte per cycle while out_stall is low. A dropped position is accepted and discarded.
// Reset (synchronous, active low) empties both stages and sets the address to 0x78.
// ----------------------------------------------------------------------------
// OLED character to I2C bytes
// Expands one character at a text position into the 27 bus bytes of nine
// three-byte write transactions: three cursor commands and six glyph columns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oled_char_to_i2c_bytes #(
  parameter int unsigned PAGE_COUNT  = ocib_pkg::PAGE_COUNT_DEF,
  parameter int unsigned PIXEL_WIDTH = ocib_pkg::PIXEL_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration port: the display's write address.
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  // Input channel: one character per transaction.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] in_text_line,
  input  wire logic [4:0] in_text_column,
  input  wire logic [7:0] in_char_code,
  // Result channel: one bus byte per transaction.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_bus_byte,
  output logic            out_start_before,
  output logic            out_stop_after,
  output logic            out_last_byte
);

  // The page and column limits are compared in narrow form. The cursor x
  // position never exceeds 127, so its saturated value fits seven bits.
  localparam logic [4:0] PAGE_LIMIT = 5'(PAGE_COUNT);
  localparam logic [7:0] X_MAX      = 8'(PIXEL_WIDTH - 1);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [7:0] dev_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= ocib_pkg::ADDR_RESET;
    end else if (cfg_wr_en) begin
      dev_addr_r <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Input stage
  // The position is checked here: an item off the display is dropped on
  // acceptance and never reaches the sequencer. For a valid item the page,
  // the saturated x position and the font index are held until the
  // sequencer is free to take them.
  // --------------------------------------------------------------------------
  logic       hold_valid_r;
  logic [2:0] hold_page_r;
  logic [6:0] hold_x_r;
  logic [6:0] hold_glyph_r;

  logic       item_ok;
  logic [7:0] x_full;
  logic [6:0] x_sat;
  logic [6:0] glyph_idx;
  logic       in_accept;
  logic       load;
  logic       last_take;
  logic       hold_valid_nxt;

  always_comb begin
    item_ok = ({1'b0, in_text_line} < PAGE_LIMIT) && (in_text_column <= ocib_pkg::MAX_COLUMN);
    // x = column * 6, formed from two shifts.
    x_full  = ({3'd0, in_text_column} << 2) + ({3'd0, in_text_column} << 1);
    x_sat   = (x_full > X_MAX) ? X_MAX[6:0] : x_full[6:0];
    if (in_char_code >= ocib_pkg::CODE_FIRST && in_char_code <= ocib_pkg::CODE_LAST) begin
      glyph_idx = 7'(in_char_code - ocib_pkg::CODE_FIRST);
    end else begin
      glyph_idx = 7'd0;
    end
  end

  // The held item moves on when the sequencer is empty or hands over its
  // final byte in this cycle, so consecutive characters leave no gap.
  assign load      = hold_valid_r && (!out_valid || last_take);
  assign in_stall  = hold_valid_r && !load;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = (hold_valid_r && !load) || (in_accept && item_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_page_r  <= in_text_line[2:0];
      hold_x_r     <= x_sat;
      hold_glyph_r <= glyph_idx;
    end
  end

  // --------------------------------------------------------------------------
  // Byte sequencer
  // The font row is fetched once when an item is loaded and kept as six
  // column bytes. Two counters walk the nine transactions and the three
  // bytes within each; the result fields are decoded from them.
  // --------------------------------------------------------------------------
  logic       cur_valid_r;
  logic [3:0] txn_r;
  logic [1:0] pos_r;
  logic [2:0] page_r;
  logic [6:0] x_r;
  logic [7:0] glyph_r [6];

  logic        cur_valid_nxt;
  logic [3:0]  txn_nxt;
  logic [1:0]  pos_nxt;
  logic        take;
  logic [47:0] glyph_row;
  logic [3:0]  glyph_off;
  logic [2:0]  glyph_sel;

  assign take      = cur_valid_r && !out_stall;
  assign last_take = take && (txn_r == ocib_pkg::TXN_LAST) && (pos_r == ocib_pkg::POS_PAYLOAD);
  assign glyph_row = ocib_pkg::font_glyph(hold_glyph_r);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    txn_nxt       = txn_r;
    pos_nxt       = pos_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      txn_nxt       = ocib_pkg::TXN_PAGE;
      pos_nxt       = ocib_pkg::POS_ADDR;
    end else if (last_take) begin
      cur_valid_nxt = 1'b0;
    end else if (take) begin
      if (pos_r == ocib_pkg::POS_PAYLOAD) begin
        pos_nxt = ocib_pkg::POS_ADDR;
        txn_nxt = txn_r + 4'd1;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      txn_r       <= ocib_pkg::TXN_PAGE;
      pos_r       <= ocib_pkg::POS_ADDR;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      txn_r       <= txn_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      page_r <= hold_page_r;
      x_r    <= hold_x_r;
      for (int i = 0; i < 6; i++) begin
        glyph_r[i] <= glyph_row[47 - 8*i -: 8];
      end
    end
  end

  // Result decode. Each transaction is address, control, payload; the start
  // mark sits on the address byte and the stop mark on the payload byte.
  assign glyph_off = txn_r - ocib_pkg::TXN_GLYPH0;
  assign glyph_sel = glyph_off[2:0];

  always_comb begin
    out_bus_byte = dev_addr_r;
    case (pos_r)
      ocib_pkg::POS_ADDR: begin
        out_bus_byte = dev_addr_r;
      end
      ocib_pkg::POS_CTRL: begin
        out_bus_byte = (txn_r < ocib_pkg::TXN_GLYPH0) ? ocib_pkg::CTRL_CMD : ocib_pkg::CTRL_DATA;
      end
      ocib_pkg::POS_PAYLOAD: begin
        case (txn_r)
          ocib_pkg::TXN_PAGE:   out_bus_byte = ocib_pkg::CMD_PAGE | {5'd0, page_r};
          ocib_pkg::TXN_COL_HI: out_bus_byte = ocib_pkg::CMD_COL_HI | {5'd0, x_r[6:4]};
          ocib_pkg::TXN_COL_LO: out_bus_byte = ocib_pkg::CMD_COL_LO | {4'd0, x_r[3:0]};
          default:              out_bus_byte = glyph_r[glyph_sel];
        endcase
      end
      default: begin
        out_bus_byte = dev_addr_r;
      end
    endcase
  end

  assign out_valid        = cur_valid_r;
  assign out_start_before = (pos_r == ocib_pkg::POS_ADDR);
  assign out_stop_after   = (pos_r == ocib_pkg::POS_PAYLOAD);
  assign out_last_byte    = (txn_r == ocib_pkg::TXN_LAST) && (pos_r == ocib_pkg::POS_PAYLOAD);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // A character that is part-way through keeps the result channel busy.
  a_no_gap_in_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_byte) |=> out_valid)
    else $error("result stream broke off inside a character");

  // After the final byte the next character follows at once if one is held.
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_byte) |=> (out_valid == $past(hold_valid_r)))
    else $error("handover between characters went wrong");

  // The input side is only held off while an item is waiting.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> hold_valid_r)
    else $error("input stalled with the input stage empty");

  // Every byte opening a transaction is the display address.
  a_start_is_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_start_before) |-> (out_bus_byte == dev_addr_r && !out_stop_after))
    else $error("transaction did not open with the address byte");
`endif

endmodule

`default_nettype wire

>>> sim/oled_char_to_i2c_bytes_tb.sv
// ----------------------------------------------------------------------------
// OLED character to I2C bytes: self-checking testbench
// Drives characters at text positions into the renderer and checks every bus
// byte against an in-bench glyph predictor. A directed table runs first, then
// random characters under three idling regimes and several display addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oled_char_to_i2c_bytes_tb;

  localparam int PAGES        = ocib_pkg::PAGE_COUNT_DEF;
  localparam int PIXEL_W      = ocib_pkg::PIXEL_WIDTH_DEF;
  localparam int DIRECTED_N   = 17;
  localparam int PHASE_CHARS  = 128;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 6;
  localparam int CYCLE_LIMIT  = 400000;

  // How a stimulus row is checked: typed-in cursor bytes and glyph, no bytes
  // at all, or the predictor.
  typedef enum logic [1:0] {
    ROW_TYPED,
    ROW_DROPPED,
    ROW_PREDICTED
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [3:0]  line;
    logic [4:0]  column;
    logic [7:0]  code;
    logic [7:0]  page_cmd;
    logic [7:0]  col_hi_cmd;
    logic [7:0]  col_lo_cmd;
    logic [47:0] glyph;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       last_byte;
  } bus_byte_t;

  // The 6x8 font for codes 32 to 126, code 32 in the top 48 bits. Within an
  // entry the leftmost pixel column is the top byte.
  localparam logic [95*48-1:0] FONT_BITS = {
    48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
    48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
    48'h001C22410000, 48'h0041221C0000, 48'h14083E081400, 48'h08083E080800,
    48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
    48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
    48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
    48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
    48'h081422410000, 48'h141414141400, 48'h004122140800, 48'h020151090600,
    48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
    48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497A00,
    48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
    48'h7F4040404000, 48'h7F020C027F00, 48'h7F0408107F00, 48'h3E4141413E00,
    48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
    48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h3F4038403F00,
    48'h631408146300, 48'h070870080700, 48'h615149454300, 48'h007F41410000,
    48'h020408102000, 48'h0041417F0000, 48'h040201020400, 48'h404040404000,
    48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
    48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h0C5252523E00,
    48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h7F1028440000,
    48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
    48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
    48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
    48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h000836410000,
    48'h00007F000000, 48'h004136080000, 48'h080408100800
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] in_text_line;
  logic [4:0] in_text_column;
  logic [7:0] in_char_code;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_bus_byte;
  logic       out_start_before;
  logic       out_stop_after;
  logic       out_last_byte;

  // Bench state. The address copy follows every register write; the row on
  // the input port tells the monitor how to build its expectation.
  bus_byte_t  bus_bytes_due[$];
  logic [7:0] addr_copy;
  stim_row_t  row_on_port;
  int         fail_count;
  int         cycle_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_requests;
  int         hold_taken;
  int         hold_left;

  oled_char_to_i2c_bytes dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_line     (in_text_line),
    .in_text_column   (in_text_column),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bus_byte     (out_bus_byte),
    .out_start_before (out_start_before),
    .out_stop_after   (out_stop_after),
    .out_last_byte    (out_last_byte)
  );

  always #5 clk = ~clk;

  function automatic logic [47:0] glyph_of(input logic [6:0] idx);
    return FONT_BITS[(94 - int'(idx)) * 48 +: 48];
  endfunction

  // One write transaction: address with start, control byte, payload with stop.
  function automatic void push_write(input logic [7:0] ctrl, input logic [7:0] payload,
                                     input logic closes_char);
    bus_bytes_due.push_back('{addr_copy, 1'b1, 1'b0, 1'b0});
    bus_bytes_due.push_back('{ctrl, 1'b0, 1'b0, 1'b0});
    bus_bytes_due.push_back('{payload, 1'b0, 1'b1, closes_char});
  endfunction

  // Three cursor commands and six glyph columns, left to right.
  function automatic void push_char_bytes(input logic [7:0] page_cmd,
                                          input logic [7:0] col_hi_cmd,
                                          input logic [7:0] col_lo_cmd,
                                          input logic [47:0] glyph);
    int i;
    push_write(ocib_pkg::CTRL_CMD, page_cmd, 1'b0);
    push_write(ocib_pkg::CTRL_CMD, col_hi_cmd, 1'b0);
    push_write(ocib_pkg::CTRL_CMD, col_lo_cmd, 1'b0);
    for (i = 0; i < 6; i++) begin
      push_write(ocib_pkg::CTRL_DATA, glyph[47 - 8 * i -: 8], i == 5);
    end
  endfunction

  // Predicts the bus bytes for one character; a position off the display
  // yields none, and a code without a glyph is drawn as a space.
  function automatic void predict_char_bytes(input logic [3:0] line,
                                             input logic [4:0] column,
                                             input logic [7:0] code);
    logic [7:0] x;
    logic [7:0] glyph_idx;
    if (int'(line) >= PAGES || column > ocib_pkg::MAX_COLUMN) begin
      return;
    end
    glyph_idx = (code >= ocib_pkg::CODE_FIRST && code <= ocib_pkg::CODE_LAST) ?
                code - ocib_pkg::CODE_FIRST : 8'd0;
    x = {3'b000, column} * 8'd6;
    if (int'(x) >= PIXEL_W) begin
      x = 8'(PIXEL_W - 1);
    end
    push_char_bytes(ocib_pkg::CMD_PAGE | {4'h0, line},
                    ocib_pkg::CMD_COL_HI | {4'h0, x[7:4]},
                    ocib_pkg::CMD_COL_LO | {4'h0, x[3:0]},
                    glyph_of(glyph_idx[6:0]));
  endfunction

  // The directed table. Typed rows carry their cursor bytes and glyph as read
  // straight off the font; dropped rows expect nothing at all.
  function automatic stim_row_t directed_row(input int n);
    stim_row_t r;
    r = '{ROW_PREDICTED, 4'd0, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00, 48'h0};
    case (n)
      0:  r = '{ROW_TYPED, 4'd0, 5'd0, 8'h00, 8'hB0, 8'h10, 8'h00, 48'h000000000000};
      1:  r = '{ROW_TYPED, 4'd7, 5'd20, 8'd126, 8'hB7, 8'h17, 8'h08, 48'h080408100800};
      2:  r = '{ROW_TYPED, 4'd0, 5'd0, 8'hFF, 8'hB0, 8'h10, 8'h00, 48'h000000000000};
      3:  r = '{ROW_TYPED, 4'd3, 5'd1, 8'd33, 8'hB3, 8'h10, 8'h06, 48'h00005F000000};
      4:  r = '{ROW_DROPPED, 4'd8, 5'd0, 8'd65, 8'h00, 8'h00, 8'h00, 48'h0};
      5:  r = '{ROW_DROPPED, 4'd15, 5'd31, 8'hFF, 8'h00, 8'h00, 8'h00, 48'h0};
      6:  r = '{ROW_DROPPED, 4'd0, 5'd21, 8'd65, 8'h00, 8'h00, 8'h00, 48'h0};
      7:  r = '{ROW_DROPPED, 4'd7, 5'd31, 8'd90, 8'h00, 8'h00, 8'h00, 48'h0};
      8:  r.line = 4'd5;
      9:  r = '{ROW_PREDICTED, 4'd2, 5'd19, 8'd127, 8'h00, 8'h00, 8'h00, 48'h0};
      10: r = '{ROW_PREDICTED, 4'd1, 5'd2, 8'd32, 8'h00, 8'h00, 8'h00, 48'h0};
      11: r = '{ROW_PREDICTED, 4'd6, 5'd15, 8'd65, 8'h00, 8'h00, 8'h00, 48'h0};
      12: r = '{ROW_PREDICTED, 4'd4, 5'd11, 8'd122, 8'h00, 8'h00, 8'h00, 48'h0};
      13: r = '{ROW_PREDICTED, 4'd7, 5'd16, 8'd128, 8'h00, 8'h00, 8'h00, 48'h0};
      14: r = '{ROW_PREDICTED, 4'd4, 5'd5, 8'h55, 8'h00, 8'h00, 8'h00, 48'h0};
      15: r = '{ROW_PREDICTED, 4'd3, 5'd10, 8'hAA, 8'h00, 8'h00, 8'h00, 48'h0};
      16: r = '{ROW_PREDICTED, 4'd5, 5'd10, 8'd31, 8'h00, 8'h00, 8'h00, 48'h0};
      default: r = r;
    endcase
    return r;
  endfunction

  // Offers one character, with random idle cycles in front of it, and holds
  // it steady until the block takes it.
  task automatic send_char(input stim_row_t row);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    row_on_port    = row;
    in_text_line   = row.line;
    in_text_column = row.column;
    in_char_code   = row.code;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted bus byte has arrived.
  task automatic drain_bytes();
    @(negedge clk);
    in_valid = 1'b0;
    while (bus_bytes_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Writes the display address once the block is idle: the queue of predicted
  // bus bytes is drained first, then the bench waits before the write.
  task automatic write_address(input logic [7:0] value);
    drain_bytes();
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    addr_copy = value;
  endtask

  // Random characters: most land on the display with a mix of printable and
  // unprintable codes; the rest are anywhere and are often dropped. Only
  // characters that draw count towards the phase. Half way through, the
  // sender pauses until the block has emptied.
  task automatic random_chars(input int count);
    stim_row_t row;
    int        drawn;
    bit        paused;
    drawn  = 0;
    paused = 1'b0;
    while (drawn < count) begin
      row = '{ROW_PREDICTED, 4'd0, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00, 48'h0};
      if ($urandom_range(0, 99) < 85) begin
        row.line   = 4'($urandom_range(0, PAGES - 1));
        row.column = 5'($urandom_range(0, int'(ocib_pkg::MAX_COLUMN)));
      end else begin
        row.line   = 4'($urandom);
        row.column = 5'($urandom);
      end
      if ($urandom_range(0, 99) < 70) begin
        row.code = 8'($urandom_range(int'(ocib_pkg::CODE_FIRST), int'(ocib_pkg::CODE_LAST)));
      end else begin
        row.code = 8'($urandom);
      end
      if (int'(row.line) < PAGES && row.column <= ocib_pkg::MAX_COLUMN) begin
        drawn++;
      end
      send_char(row);
      if (!paused && drawn >= count / 2) begin
        paused = 1'b1;
        drain_bytes();
      end
    end
  endtask

  // Receiver: a requested long hold-off takes precedence, counted down here;
  // otherwise it stalls at random at the rate of the current phase.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall = 1'b1;
    end else if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left  = HOLD_CYCLES - 1;
      out_stall  = 1'b1;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: builds expectations for each accepted character and checks each
  // accepted bus byte against the oldest one.
  always @(posedge clk) begin : monitor
    bus_byte_t due;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        case (row_on_port.kind)
          ROW_TYPED: begin
            push_char_bytes(row_on_port.page_cmd, row_on_port.col_hi_cmd,
                            row_on_port.col_lo_cmd, row_on_port.glyph);
          end
          ROW_DROPPED: begin
          end
          default: begin
            predict_char_bytes(in_text_line, in_text_column, in_char_code);
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (bus_bytes_due.size() == 0) begin
          $error("bus byte %h arrived with nothing expected", out_bus_byte);
          fail_count++;
        end else begin
          due = bus_bytes_due.pop_front();
          if (out_bus_byte !== due.bus_byte) begin
            $error("bus_byte: expected %h, got %h", due.bus_byte, out_bus_byte);
            fail_count++;
          end
          if (out_start_before !== due.start_before) begin
            $error("start_before: expected %0b, got %0b", due.start_before, out_start_before);
            fail_count++;
          end
          if (out_stop_after !== due.stop_after) begin
            $error("stop_after: expected %0b, got %0b", due.stop_after, out_stop_after);
            fail_count++;
          end
          if (out_last_byte !== due.last_byte) begin
            $error("last_byte: expected %0b, got %0b", due.last_byte, out_last_byte);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 8'h00;
    in_valid       = 1'b0;
    in_text_line   = 4'd0;
    in_text_column = 5'd0;
    in_char_code   = 8'h00;
    out_stall      = 1'b0;
    addr_copy      = ocib_pkg::ADDR_RESET;
    row_on_port    = '{ROW_PREDICTED, 4'd0, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00, 48'h0};
    fail_count     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_requests  = 0;
    hold_taken     = 0;
    hold_left      = 0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed table under the address left by reset, light idling.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    for (n = 0; n < DIRECTED_N; n++) begin
      send_char(directed_row(n));
    end

    // Sender idles lightly, receiver heavily.
    write_address(8'h00);
    send_idle_pct = 20;
    recv_idle_pct = 71;
    random_chars(PHASE_CHARS);

    // The other way round, opening with a long receiver hold-off while the
    // sender keeps offering so the block backs up into its input.
    write_address(8'hFF);
    send_idle_pct = 71;
    recv_idle_pct = 20;
    hold_requests++;
    random_chars(PHASE_CHARS);

    // Full rate on both sides.
    write_address(8'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_chars(PHASE_CHARS);

    drain_bytes();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
